// File: hdl/ssx_pkg.sv
package ssx_pkg;

    localparam int MAX_DIM     = 1024;
    localparam int MAX_ENTRIES = 4096;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int ROW_W  = $clog2(MAX_DIM);
    localparam int ENT_AW = $clog2(MAX_ENTRIES);
    localparam int PTR_W  = 13;
    localparam int VAL_W  = 64;
    localparam int ENT_W  = ROW_W + VAL_W;

    typedef enum logic [2:0] {
        CMD_LOAD_PTR   = 3'd0,
        CMD_LOAD_ENTRY = 3'd1,
        CMD_ROW_PICK   = 3'd2,
        CMD_COL_PICK   = 3'd3,
        CMD_RUN        = 3'd4,
        CMD_READ_PTR   = 3'd5,
        CMD_READ_ENTRY = 3'd6,
        CMD_UNUSED     = 3'd7
    } command_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ROW_OOB = 2'd1,
        ST_COL_OOB = 2'd2,
        ST_OVFL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_SOURCE_ROWS = 2'd0,
        CFG_SOURCE_COLS = 2'd1,
        CFG_PICKED_ROWS = 2'd2,
        CFG_PICKED_COLS = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        RK_NONE  = 2'd0,
        RK_PTR   = 2'd1,
        RK_ENTRY = 2'd2
    } read_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHKR_RD,
        S_CHKR_EV,
        S_CHKC_RD,
        S_CHKC_EV,
        S_COL_RD,
        S_PTR0,
        S_PTR1,
        S_PTR2,
        S_ENT_RD,
        S_PICK_RD,
        S_PICK_EV
    } state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [12:0] addr;
        logic [12:0] word;
        logic [63:0] value_bits;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] entry_count;
        logic [12:0] pointer_out;
        logic [9:0]  row_out;
        logic [63:0] value_out;
    } res_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [10:0] v);
        logic [DIM_W-1:0] r;
        if (v > 11'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

endpackage

// File: hdl/sparse_csc_submatrix_extract_unit.sv
// Command-driven extractor of a submatrix from a compressed-sparse-column matrix. Each command
// word is taken when start is high and busy is low and returns one result word, marked by
// result_valid for one cycle, which the receiver must take. Load and read commands leave busy
// low, so they can follow each other back to back. A run keeps busy high while it walks the
// stores: first it checks every row and then every column subscript and stops on a bad one,
// then, per picked column, it reads the column subscript and its two source pointers and
// compares each stored entry of that column against every row subscript, read one at a time
// from the row pick store, and last it closes the pointer list.
module sparse_csc_submatrix_extract_unit
    import ssx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        result_valid,
    output res_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    state_t state_reg, state_next;

    logic [10:0] src_rows_reg, src_cols_reg, pk_rows_reg, pk_cols_reg;
    logic [DIM_W-1:0] k_reg, k_next, h_reg, h_next;
    logic [ROW_W-1:0] c_reg, c_next;
    logic [PTR_W-1:0] e_reg, e_next, end_reg, end_next, n_reg, n_next;
    logic [PTR_W-1:0] out_count_reg, out_count_next;
    logic full_reg, full_next;
    logic res_valid_reg, res_valid_next;
    logic [1:0] res_status_reg, res_status_next;
    read_kind_t res_kind_reg, res_kind_next;

    logic [DIM_W-1:0] nr, nc, rbound, cbound;
    logic accept;

    logic sp_we, sp_re, ep_we, ep_re, rp_we, rp_re, cp_we, cp_re;
    logic op_we, op_re, oe_we, oe_re;
    logic [DIM_W-1:0] sp_waddr, sp_raddr, op_waddr, op_raddr;
    logic [ENT_AW-1:0] ep_raddr, oe_waddr;
    logic [ROW_W-1:0] rp_raddr, cp_raddr;
    logic [PTR_W-1:0] sp_rdata, op_rdata, op_wdata;
    logic [ENT_W-1:0] ep_rdata, oe_rdata, oe_wdata;
    logic [10:0] rp_rdata, cp_rdata;
    logic [10:0] entry_row_p1;

    assign nr     = clamp_dim(pk_rows_reg);
    assign nc     = clamp_dim(pk_cols_reg);
    assign rbound = clamp_dim(src_rows_reg);
    assign cbound = clamp_dim(src_cols_reg);
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign cfg_ready = 1'b1;
    assign entry_row_p1 = {1'b0, ep_rdata[ENT_W-1:VAL_W]} + 11'd1;

    ssx_ram #(.DEPTH(MAX_DIM + 1), .WIDTH(PTR_W)) u_src_ptr (
        .clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(cmd.word),
        .re(sp_re), .raddr(sp_raddr), .rdata(sp_rdata)
    );
    ssx_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(ENT_W)) u_src_ent (
        .clk(clk), .we(ep_we), .waddr(cmd.addr[ENT_AW-1:0]),
        .wdata({cmd.word[ROW_W-1:0], cmd.value_bits}),
        .re(ep_re), .raddr(ep_raddr), .rdata(ep_rdata)
    );
    ssx_ram #(.DEPTH(MAX_DIM), .WIDTH(11)) u_row_pick (
        .clk(clk), .we(rp_we), .waddr(cmd.addr[ROW_W-1:0]), .wdata(cmd.word[10:0]),
        .re(rp_re), .raddr(rp_raddr), .rdata(rp_rdata)
    );
    ssx_ram #(.DEPTH(MAX_DIM), .WIDTH(11)) u_col_pick (
        .clk(clk), .we(cp_we), .waddr(cmd.addr[ROW_W-1:0]), .wdata(cmd.word[10:0]),
        .re(cp_re), .raddr(cp_raddr), .rdata(cp_rdata)
    );
    ssx_ram #(.DEPTH(MAX_DIM + 1), .WIDTH(PTR_W)) u_out_ptr (
        .clk(clk), .we(op_we), .waddr(op_waddr), .wdata(op_wdata),
        .re(op_re), .raddr(op_raddr), .rdata(op_rdata)
    );
    ssx_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(ENT_W)) u_out_ent (
        .clk(clk), .we(oe_we), .waddr(oe_waddr), .wdata(oe_wdata),
        .re(oe_re), .raddr(cmd.addr[ENT_AW-1:0]), .rdata(oe_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.command == CMD_RUN)
                    state_next = S_CHKR_RD;
            end
            S_CHKR_RD: state_next = (k_reg >= nr) ? S_CHKC_RD : S_CHKR_EV;
            S_CHKR_EV:
            begin
                if (rp_rdata == 11'd0 || rp_rdata > 11'(rbound))
                    state_next = S_IDLE;
                else
                    state_next = S_CHKR_RD;
            end
            S_CHKC_RD: state_next = (k_reg >= nc) ? S_COL_RD : S_CHKC_EV;
            S_CHKC_EV:
            begin
                if (cp_rdata == 11'd0 || cp_rdata > 11'(cbound))
                    state_next = S_IDLE;
                else
                    state_next = S_CHKC_RD;
            end
            S_COL_RD:  state_next = (h_reg >= nc) ? S_IDLE : S_PTR0;
            S_PTR0:    state_next = full_reg ? S_COL_RD : S_PTR1;
            S_PTR1:    state_next = S_PTR2;
            S_PTR2:    state_next = S_ENT_RD;
            S_ENT_RD:  state_next = (e_reg >= end_reg || full_reg) ? S_COL_RD : S_PICK_RD;
            S_PICK_RD: state_next = (k_reg >= nr) ? S_ENT_RD : S_PICK_EV;
            S_PICK_EV:
            begin
                if (rp_rdata == entry_row_p1 && n_reg >= PTR_W'(MAX_ENTRIES))
                    state_next = S_ENT_RD;
                else
                    state_next = S_PICK_RD;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        k_next = k_reg;
        h_next = h_reg;
        c_next = c_reg;
        e_next = e_reg;
        end_next = end_reg;
        n_next = n_reg;
        full_next = full_reg;
        out_count_next = out_count_reg;
        res_valid_next = 1'b0;
        res_status_next = res_status_reg;
        res_kind_next = res_kind_reg;
        sp_we = 1'b0; sp_re = 1'b0; sp_waddr = cmd.addr[DIM_W-1:0]; sp_raddr = DIM_W'(c_reg);
        ep_we = 1'b0; ep_re = 1'b0; ep_raddr = e_reg[ENT_AW-1:0];
        rp_we = 1'b0; rp_re = 1'b0; rp_raddr = k_reg[ROW_W-1:0];
        cp_we = 1'b0; cp_re = 1'b0; cp_raddr = k_reg[ROW_W-1:0];
        op_we = 1'b0; op_re = 1'b0; op_waddr = h_reg; op_wdata = n_reg;
        op_raddr = cmd.addr[DIM_W-1:0];
        oe_we = 1'b0; oe_re = 1'b0; oe_waddr = n_reg[ENT_AW-1:0];
        oe_wdata = {k_reg[ROW_W-1:0], ep_rdata[VAL_W-1:0]};
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_kind_next = RK_NONE;
                    res_valid_next = (cmd.command != CMD_RUN);
                    k_next = '0;
                    unique case (command_t'(cmd.command))
                        CMD_LOAD_PTR:   sp_we = (cmd.addr < 13'(MAX_DIM + 1));
                        CMD_LOAD_ENTRY: ep_we = (cmd.addr < 13'(MAX_ENTRIES));
                        CMD_ROW_PICK:   rp_we = (cmd.addr < 13'(MAX_DIM));
                        CMD_COL_PICK:   cp_we = (cmd.addr < 13'(MAX_DIM));
                        CMD_READ_PTR:
                        begin
                            if (cmd.addr < 13'(MAX_DIM + 1))
                            begin
                                op_re = 1'b1;
                                res_kind_next = RK_PTR;
                            end
                        end
                        CMD_READ_ENTRY:
                        begin
                            if (cmd.addr < 13'(MAX_ENTRIES))
                            begin
                                oe_re = 1'b1;
                                res_kind_next = RK_ENTRY;
                            end
                        end
                        CMD_RUN, CMD_UNUSED: ;
                        default: ;
                    endcase
                end
            end
            S_CHKR_RD:
            begin
                rp_re = (k_reg < nr);
                if (k_reg >= nr)
                    k_next = '0;
            end
            S_CHKR_EV:
            begin
                if (rp_rdata == 11'd0 || rp_rdata > 11'(rbound))
                begin
                    res_valid_next = 1'b1;
                    res_status_next = ST_ROW_OOB;
                end
                k_next = k_reg + 1'b1;
            end
            S_CHKC_RD:
            begin
                cp_re = (k_reg < nc);
                if (k_reg >= nc)
                begin
                    h_next = '0;
                    n_next = '0;
                    full_next = 1'b0;
                end
            end
            S_CHKC_EV:
            begin
                if (cp_rdata == 11'd0 || cp_rdata > 11'(cbound))
                begin
                    res_valid_next = 1'b1;
                    res_status_next = ST_COL_OOB;
                end
                k_next = k_reg + 1'b1;
            end
            S_COL_RD:
            begin
                cp_raddr = h_reg[ROW_W-1:0];
                if (h_reg >= nc)
                begin
                    op_we = 1'b1;
                    out_count_next = n_reg;
                    res_valid_next = 1'b1;
                    res_status_next = full_reg ? ST_OVFL : ST_OK;
                end
                else
                begin
                    cp_re = 1'b1;
                end
            end
            S_PTR0:
            begin
                op_we = 1'b1;
                c_next = ROW_W'(cp_rdata - 11'd1);
                sp_raddr = DIM_W'(cp_rdata - 11'd1);
                if (full_reg)
                    h_next = h_reg + 1'b1;
                else
                    sp_re = 1'b1;
            end
            S_PTR1:
            begin
                e_next = sp_rdata;
                sp_raddr = DIM_W'(c_reg) + 1'b1;
                sp_re = 1'b1;
            end
            S_PTR2:
            begin
                end_next = (sp_rdata > PTR_W'(MAX_ENTRIES)) ? PTR_W'(MAX_ENTRIES) : sp_rdata;
            end
            S_ENT_RD:
            begin
                k_next = '0;
                if (e_reg >= end_reg || full_reg)
                    h_next = h_reg + 1'b1;
                else
                    ep_re = 1'b1;
            end
            S_PICK_RD:
            begin
                rp_re = (k_reg < nr);
                if (k_reg >= nr)
                    e_next = e_reg + 1'b1;
            end
            S_PICK_EV:
            begin
                k_next = k_reg + 1'b1;
                if (rp_rdata == entry_row_p1)
                begin
                    if (n_reg >= PTR_W'(MAX_ENTRIES))
                        full_next = 1'b1;
                    else
                    begin
                        oe_we = 1'b1;
                        n_next = n_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            src_rows_reg <= 11'd1;
            src_cols_reg <= 11'd1;
            pk_rows_reg <= '0;
            pk_cols_reg <= '0;
            out_count_reg <= '0;
            res_valid_reg <= 1'b0;
            full_reg <= 1'b0;
            res_kind_reg <= RK_NONE;
            res_status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            out_count_reg <= out_count_next;
            res_valid_reg <= res_valid_next;
            full_reg <= full_next;
            res_kind_reg <= res_kind_next;
            res_status_reg <= res_status_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_SOURCE_ROWS: src_rows_reg <= cfg_data;
                    CFG_SOURCE_COLS: src_cols_reg <= cfg_data;
                    CFG_PICKED_ROWS: pk_rows_reg <= cfg_data;
                    CFG_PICKED_COLS: pk_cols_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        h_reg <= h_next;
        c_reg <= c_next;
        e_reg <= e_next;
        end_reg <= end_next;
        n_reg <= n_next;
    end

    always_comb
    begin
        result = '0;
        result.status = res_status_reg;
        result.entry_count = out_count_reg;
        if (res_kind_reg == RK_PTR)
            result.pointer_out = op_rdata;
        if (res_kind_reg == RK_ENTRY)
        begin
            result.row_out = oe_rdata[ENT_W-1:VAL_W];
            result.value_out = oe_rdata[VAL_W-1:0];
        end
    end
    assign result_valid = res_valid_reg;

    a_no_word_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !result_valid) else $error("result word during run");
    a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.command != CMD_RUN) |=> result_valid) else $error("missing result word");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg <= PTR_W'(MAX_ENTRIES)) else $error("entry count beyond store");
    a_full_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && state_reg != S_IDLE) |-> n_reg == PTR_W'(MAX_ENTRIES))
        else $error("overflow below limit");

endmodule

// File: hdl/ssx_ram.sv
module ssx_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
